// File: hw/rtl/gpurc_pkg.sv
// Shared constants, codes and the work item carried from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package gpurc_pkg;

   localparam int GRID_DIM        = 256;
   localparam int COORD_W         = $clog2(GRID_DIM);
   localparam int IDX_W           = $clog2(GRID_DIM + 1);
   localparam int ADDR_W          = 2 * COORD_W;
   localparam int SIZE_W          = 9;
   localparam int COUNT_W         = 17;
   localparam int GRID_SIZE_RESET = 256;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] MODE_SET    = 2'd0;
   localparam logic [1:0] MODE_TOGGLE = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      OP_UPDATE,
      OP_QUERY,
      OP_ZERO
   } op_type;

   // Update: row_lo/col_lo hold the cell. Query: row_end/col_end are exclusive bounds.
   typedef struct packed {
      op_type             op;
      logic               toggle;
      logic               cell_value;
      logic [IDX_W-1:0]   row_lo;
      logic [IDX_W-1:0]   col_lo;
      logic [IDX_W-1:0]   row_end;
      logic [IDX_W-1:0]   col_end;
   } work_type;

endpackage

// File: hw/rtl/grid_point_update_rectangle_count_unit.sv
// Grid point update and rectangle count: a 256 x 256 grid of one-bit cells with a two-dimensional
// tree of cell counts. Set and toggle transactions change one cell and give no result; a query
// transaction returns the number of set cells in an inclusive rectangle clipped to grid_size.
// After reset the cell and tree memories are swept to zero, one entry per cycle, over all 65536 entries,
// during which req_full stays high. A query reads tree nodes over four prefix walks (up to
// 4 x 8 x 8 nodes, often far fewer); an update reads the cell and, if the bit changes, does
// a read and a write per node (up to 9 x 9 nodes). The tree memory is single-ported.
// A two-entry queue lets new transactions be taken while one is being worked on, and the
// result register lets the next one start while a result waits.
// Depends on gpurc_pkg, gpurc_front, gpurc_queue and gpurc_back.
`timescale 1ns / 1ps

module grid_point_update_rectangle_count_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_mode,
   input  logic [7:0]                    req_row_lo,
   input  logic [7:0]                    req_col_lo,
   input  logic [7:0]                    req_row_hi,
   input  logic [7:0]                    req_col_hi,
   input  logic                          req_cell_value,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [gpurc_pkg::COUNT_W-1:0] rsp_count,
   input  logic                          csr_write,
   input  logic [gpurc_pkg::SIZE_W-1:0]  csr_data
);
   import gpurc_pkg::*;

   work_type push_data, head;
   logic     q_push, q_full, q_pop, q_empty, clearing;

   gpurc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_row_lo     (req_row_lo),
      .req_col_lo     (req_col_lo),
      .req_row_hi     (req_row_hi),
      .req_col_hi     (req_col_hi),
      .req_cell_value (req_cell_value),
      .csr_write      (csr_write),
      .csr_data       (csr_data),
      .queue_full     (q_full),
      .clearing       (clearing),
      .queue_push     (q_push),
      .queue_data     (push_data)
   );

   gpurc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (head)
   );

   gpurc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .queue_head  (head),
      .queue_pop   (q_pop),
      .clearing    (clearing),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_count   (rsp_count)
   );

endmodule

// File: hw/rtl/gpurc_front.sv
// Front end: size register, range checks and clipping of incoming transactions.
// Depends on gpurc_pkg.
`timescale 1ns / 1ps

module gpurc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_mode,
   input  logic [7:0]                    req_row_lo,
   input  logic [7:0]                    req_col_lo,
   input  logic [7:0]                    req_row_hi,
   input  logic [7:0]                    req_col_hi,
   input  logic                          req_cell_value,
   input  logic                          csr_write,
   input  logic [gpurc_pkg::SIZE_W-1:0]  csr_data,
   input  logic                          queue_full,
   input  logic                          clearing,
   output logic                          queue_push,
   output gpurc_pkg::work_type           queue_data
);
   import gpurc_pkg::*;

   logic [SIZE_W-1:0] grid_size_ff, grid_size_in;
   logic [IDX_W-1:0]  n, rlo, clo, rhi, chi;
   logic              in_grid, keep;
   op_type            op;

   always_comb begin
      grid_size_in = csr_write ? csr_data : grid_size_ff;
      n   = (grid_size_ff < SIZE_W'(GRID_DIM)) ? IDX_W'(grid_size_ff) : IDX_W'(GRID_DIM);
      rlo = IDX_W'(req_row_lo);
      clo = IDX_W'(req_col_lo);
      rhi = IDX_W'(req_row_hi);
      chi = IDX_W'(req_col_hi);
      in_grid = (rlo < n) && (clo < n);
      unique case (req_mode)
         MODE_SET, MODE_TOGGLE: begin
            keep = in_grid;
            op   = OP_UPDATE;
         end
         MODE_QUERY: begin
            keep = 1'b1;
            op   = (rlo <= rhi && clo <= chi && in_grid) ? OP_QUERY : OP_ZERO;
         end
         default: begin
            keep = 1'b0;
            op   = OP_ZERO;
         end
      endcase
      queue_data.op         = op;
      queue_data.toggle     = (req_mode == MODE_TOGGLE);
      queue_data.cell_value = req_cell_value;
      queue_data.row_lo     = rlo;
      queue_data.col_lo     = clo;
      // clip the far corner to the grid in use
      queue_data.row_end    = (rhi >= n) ? n : rhi + 1'b1;
      queue_data.col_end    = (chi >= n) ? n : chi + 1'b1;
      req_full   = queue_full | clearing;
      queue_push = req_push & ~req_full & keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= SIZE_W'(GRID_SIZE_RESET);
      end else begin
         grid_size_ff <= grid_size_in;
      end
   end

endmodule

// File: hw/rtl/gpurc_queue.sv
// Short queue of work items between the front and back ends.
// Depends on gpurc_pkg.
`timescale 1ns / 1ps

module gpurc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gpurc_pkg::work_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output gpurc_pkg::work_type  head
);
   import gpurc_pkg::*;

   work_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
      empty   = (count_ff == '0);
      head    = slots_ff[rd_ptr_ff];
      do_push = push & ~full;
      do_pop  = pop & ~empty;
      wr_ptr_in = do_push ? ((wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1)
                          : wr_ptr_ff;
      rd_ptr_in = do_pop ? ((rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1)
                         : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/gpurc_back.sv
// Back end: cell and tree memories, update and prefix-count sequencer, result register.
// Depends on gpurc_pkg.
`timescale 1ns / 1ps

module gpurc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          queue_empty,
   input  gpurc_pkg::work_type           queue_head,
   output logic                          queue_pop,
   output logic                          clearing,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [gpurc_pkg::COUNT_W-1:0] rsp_count
);
   import gpurc_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CELL_RD, S_CELL_CHK, S_UPD_RD, S_UPD_WR,
      S_Q_START, S_Q_RD, S_Q_ACC, S_OUT
   } state_type;

   function automatic logic [IDX_W-1:0] lowbit(input logic [IDX_W-1:0] x);
      return x & (~x + 1'b1);
   endfunction

   logic               node_mem [2**ADDR_W];
   logic [COUNT_W-1:0] sum_mem [2**ADDR_W];
   logic               cell_rd_ff;
   logic [COUNT_W-1:0] node_rd_ff;

   state_type          state_ff, state_in;
   work_type           item_ff, item_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic               dec_ff, dec_in;
   logic [1:0]         phase_ff, phase_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic               out_valid_ff, out_valid_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   logic [ADDR_W-1:0]  cell_addr, node_addr;
   logic               cell_we, cell_wd, node_we;
   logic [COUNT_W-1:0] node_wd;
   logic               new_bit, neg;
   logic [IDX_W-1:0]   r_sel, c_sel, i_dn, j_dn;
   logic [IDX_W:0]     i_up, j_up;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      clr_in       = clr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      dec_in       = dec_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      out_count_in = out_count_ff;
      queue_pop    = 1'b0;
      cell_we      = 1'b0;
      cell_wd      = 1'b0;
      node_we      = 1'b0;
      node_wd      = node_rd_ff + (dec_ff ? {COUNT_W{1'b1}} : COUNT_W'(1));
      new_bit      = item_ff.toggle ? ~cell_rd_ff : item_ff.cell_value;
      unique case (phase_ff)
         2'd0:    begin r_sel = item_ff.row_end; c_sel = item_ff.col_end; end
         2'd1:    begin r_sel = item_ff.row_lo;  c_sel = item_ff.col_end; end
         2'd2:    begin r_sel = item_ff.row_end; c_sel = item_ff.col_lo;  end
         default: begin r_sel = item_ff.row_lo;  c_sel = item_ff.col_lo;  end
      endcase
      neg  = (phase_ff == 2'd1) || (phase_ff == 2'd2);
      i_up = {1'b0, i_ff} + {1'b0, lowbit(i_ff)};
      j_up = {1'b0, j_ff} + {1'b0, lowbit(j_ff)};
      i_dn = i_ff - lowbit(i_ff);
      j_dn = j_ff - lowbit(j_ff);
      cell_addr = {item_ff.row_lo[COORD_W-1:0], item_ff.col_lo[COORD_W-1:0]};
      node_addr = {COORD_W'(i_ff - 1'b1), COORD_W'(j_ff - 1'b1)};
      if (state_ff == S_CLEAR) begin
         cell_addr = clr_ff;
         node_addr = clr_ff;
      end

      unique case (state_ff)
         S_CLEAR: begin
            cell_we = 1'b1;
            node_we = 1'b1;
            node_wd = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == {ADDR_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               item_in   = queue_head;
               acc_in    = '0;
               phase_in  = '0;
               unique case (queue_head.op)
                  OP_UPDATE: state_in = S_CELL_RD;
                  OP_QUERY:  state_in = S_Q_START;
                  default:   state_in = S_OUT;
               endcase
            end
         end
         S_CELL_RD: state_in = S_CELL_CHK;
         S_CELL_CHK: begin
            if (new_bit == cell_rd_ff) begin
               state_in = S_IDLE;
            end else begin
               cell_we  = 1'b1;
               cell_wd  = new_bit;
               dec_in   = ~new_bit;
               i_in     = item_ff.row_lo + 1'b1;
               j_in     = item_ff.col_lo + 1'b1;
               state_in = S_UPD_RD;
            end
         end
         S_UPD_RD: state_in = S_UPD_WR;
         S_UPD_WR: begin
            node_we  = 1'b1;
            state_in = S_UPD_RD;
            if (j_up > (IDX_W + 1)'(GRID_DIM)) begin
               j_in = item_ff.col_lo + 1'b1;
               if (i_up > (IDX_W + 1)'(GRID_DIM)) begin
                  state_in = S_IDLE;
               end else begin
                  i_in = IDX_W'(i_up);
               end
            end else begin
               j_in = IDX_W'(j_up);
            end
         end
         S_Q_START: begin
            i_in = r_sel;
            j_in = c_sel;
            if (r_sel == '0 || c_sel == '0) begin
               phase_in = phase_ff + 1'b1;
               state_in = (phase_ff == 2'd3) ? S_OUT : S_Q_START;
            end else begin
               state_in = S_Q_RD;
            end
         end
         S_Q_RD: state_in = S_Q_ACC;
         S_Q_ACC: begin
            acc_in   = neg ? acc_ff - node_rd_ff : acc_ff + node_rd_ff;
            state_in = S_Q_RD;
            if (j_dn == '0) begin
               j_in = c_sel;
               if (i_dn == '0) begin
                  phase_in = phase_ff + 1'b1;
                  state_in = (phase_ff == 2'd3) ? S_OUT : S_Q_START;
               end else begin
                  i_in = i_dn;
               end
            end else begin
               j_in = j_dn;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_count_in = acc_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      clearing  = (state_ff == S_CLEAR);
      rsp_empty = ~out_valid_ff;
      rsp_count = out_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff      <= item_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      dec_ff       <= dec_in;
      phase_ff     <= phase_in;
      acc_ff       <= acc_in;
      out_count_ff <= out_count_in;
   end

   // cell bits
   always_ff @(posedge clock) begin
      if (cell_we) begin
         node_mem[cell_addr] <= cell_wd;
      end
      cell_rd_ff <= node_mem[cell_addr];
   end

   // tree node counts, modulo 2^COUNT_W
   always_ff @(posedge clock) begin
      if (node_we) begin
         sum_mem[node_addr] <= node_wd;
      end
      node_rd_ff <= sum_mem[node_addr];
   end

endmodule

// File: tb/grid_point_update_rectangle_count_checker.sv
// Checker for the grid point update / rectangle count unit: tracks grid contents and size,
// predicts query counts and compares them with the result channel. Depends on gpurc_pkg.
`timescale 1ns / 1ps

module grid_point_update_rectangle_count_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic                          req_full,
   input  logic [1:0]                    req_mode,
   input  logic [7:0]                    req_row_lo,
   input  logic [7:0]                    req_col_lo,
   input  logic [7:0]                    req_row_hi,
   input  logic [7:0]                    req_col_hi,
   input  logic                          req_cell_value,
   input  logic                          rsp_empty,
   input  logic                          rsp_pop,
   input  logic [gpurc_pkg::COUNT_W-1:0] rsp_count,
   input  logic                          csr_write,
   input  logic [gpurc_pkg::SIZE_W-1:0]  csr_data,
   output int                            fail_count,
   output int                            counts_pending
);
   import gpurc_pkg::*;

   bit                  cells [GRID_DIM][GRID_DIM];
   logic [SIZE_W-1:0]   grid_size;
   logic [COUNT_W-1:0]  expected_counts [$];

   assign counts_pending = expected_counts.size();

   // Brute-force count over the clipped rectangle; independent of the tree in the unit.
   function automatic logic [COUNT_W-1:0] rect_count(int rlo, int clo, int rhi, int chi);
      int n;
      int total;
      n = (int'(grid_size) < GRID_DIM) ? int'(grid_size) : GRID_DIM;
      total = 0;
      if (rlo > rhi || clo > chi || rlo >= n || clo >= n)
         return '0;
      if (rhi >= n) rhi = n - 1;
      if (chi >= n) chi = n - 1;
      for (int r = rlo; r <= rhi; r++)
         for (int c = clo; c <= chi; c++)
            total += int'(cells[r][c]);
      return total[COUNT_W-1:0];
   endfunction

   always @(posedge clock) begin
      int n;
      n = (int'(grid_size) < GRID_DIM) ? int'(grid_size) : GRID_DIM;
      if (reset) begin
         foreach (cells[r, c]) cells[r][c] = 1'b0;
         grid_size = SIZE_W'(GRID_SIZE_RESET);
         expected_counts.delete();
         fail_count = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_counts.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: count %0d", rsp_count);
            end else begin
               logic [COUNT_W-1:0] want;
               want = expected_counts.pop_front();
               if (rsp_count !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("count mismatch: expected %0d actual %0d", want, rsp_count);
               end
            end
         end
         if (req_push && !req_full) begin
            case (req_mode)
               MODE_SET: if (int'(req_row_lo) < n && int'(req_col_lo) < n)
                  cells[req_row_lo][req_col_lo] = req_cell_value;
               MODE_TOGGLE: if (int'(req_row_lo) < n && int'(req_col_lo) < n)
                  cells[req_row_lo][req_col_lo] = !cells[req_row_lo][req_col_lo];
               MODE_QUERY:
                  expected_counts = {expected_counts,
                                     rect_count(int'(req_row_lo), int'(req_col_lo),
                                                int'(req_row_hi), int'(req_col_hi))};
               default: ;
            endcase
         end
         if (csr_write) grid_size = csr_data;
      end
   end

endmodule

// File: tb/grid_point_update_rectangle_count_unit_tb.sv
// Testbench top: drives set, toggle, query and unused-mode transactions and grid_size writes into the unit,
// with random idling on both sides. Depends on gpurc_pkg, the unit and the checker.
`timescale 1ns / 1ps

module grid_point_update_rectangle_count_unit_tb;
   import gpurc_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         req_mode = MODE_SET;
   logic [7:0]         req_row_lo = '0, req_col_lo = '0, req_row_hi = '0, req_col_hi = '0;
   logic               req_cell_value = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [COUNT_W-1:0] rsp_count;
   logic               csr_write = 1'b0;
   logic [SIZE_W-1:0]  csr_data = '0;
   int                 fail_count, counts_pending;
   bit                 steady;       // no idling on either side
   bit                 hold_off = 0; // receiver stalls for a long stretch
   int                 quiet_cycles = 0;

   localparam int QUIET_LIMIT = 200000; // covers the clear sweep after reset

   always #1 clock = ~clock;

   grid_point_update_rectangle_count_unit u_top (.*);

   grid_point_update_rectangle_count_checker u_checker (.*);

   // Receiver
   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= !hold_off && (steady || $urandom_range(99) >= 37);
   end

   // Watchdog on accepted transactions
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // push stays high from one transaction to the next; idling or drain lowers it
   task automatic send(logic [1:0] mode, int rlo, int clo, int rhi, int chi, int value);
      while (!steady && $urandom_range(99) < 37) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_mode <= mode;
      req_row_lo <= rlo[7:0];
      req_col_lo <= clo[7:0];
      req_row_hi <= rhi[7:0];
      req_col_hi <= chi[7:0];
      req_cell_value <= value[0];
      do @(posedge clock); while (req_full);
   endtask

   task automatic drain;
      req_push <= 1'b0;
      while (counts_pending != 0) @(posedge clock);
      repeat (600) @(posedge clock); // a trailing update may still be in flight
   endtask

   task automatic set_size(int size);
      drain();
      csr_write <= 1'b1;
      csr_data <= size[SIZE_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic random_item(int span);
      int rlo, clo, roll;
      rlo = $urandom_range(span - 1);
      clo = $urandom_range(span - 1);
      roll = $urandom_range(99);
      if (roll < 35) send(MODE_SET, rlo, clo, $urandom, $urandom, $urandom);
      else if (roll < 55) send(MODE_TOGGLE, rlo, clo, $urandom, $urandom, $urandom);
      else if (roll < 95)
         send(MODE_QUERY, rlo, clo, $urandom_range(span - 1, rlo), $urandom_range(span - 1, clo),
              $urandom);
      else send(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int spans [4] = '{8, 24, 256, 5};
      int sizes [4] = '{0, 1, 20, 300};
      steady = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: corners, every mode, reversed and clipped rectangles, unused mode
      send(MODE_SET, 0, 0, 0, 0, 1);
      send(MODE_SET, 255, 255, 0, 0, 1);
      send(MODE_SET, 0, 255, 0, 0, 1);
      send(MODE_TOGGLE, 255, 0, 0, 0, 0);
      send(MODE_TOGGLE, 0, 0, 0, 0, 1);
      send(MODE_SET, 85, 170, 170, 85, 1);
      send(MODE_QUERY, 0, 0, 255, 255, 0);
      send(MODE_QUERY, 255, 255, 255, 255, 0);
      send(MODE_QUERY, 10, 0, 9, 255, 0);
      send(MODE_QUERY, 0, 10, 255, 9, 0);
      send(2'd3, 1, 1, 1, 1, 1);
      send(MODE_QUERY, 85, 170, 85, 170, 0);
      send(MODE_SET, 85, 170, 0, 0, 0);
      send(MODE_QUERY, 0, 0, 255, 255, 1);
      set_size(1);
      send(MODE_SET, 1, 0, 0, 0, 1);
      send(MODE_QUERY, 0, 0, 255, 255, 0);
      send(MODE_QUERY, 1, 0, 255, 255, 0);
      set_size(0);
      send(MODE_SET, 0, 0, 0, 0, 1);
      send(MODE_QUERY, 0, 0, 255, 255, 0);
      set_size(256);
      send(MODE_QUERY, 0, 0, 255, 255, 0);

      // Random phases across grid sizes; the third phase runs without idling
      for (int ph = 0; ph < 4; ph++) begin
         set_size(sizes[ph]);
         steady = (ph == 2);
         for (int k = 0; k < 95; k++) random_item(spans[ph]);
      end
      set_size(256);
      steady = 1'b0;

      // Long receiver stall so the queue fills and req_full rises
      fork
         begin
            hold_off <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_off <= 1'b0;
         end
         for (int k = 0; k < 12; k++) send(MODE_QUERY, 0, 0, 255, 255, 0);
      join
      for (int k = 0; k < 10; k++) random_item(16);

      drain();
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
